// File: rtl/afr_pkg.sv
package afr_pkg;

	localparam logic [7:0] DELIM_BYTE        = 8'h7E;
	localparam logic [7:0] CMD_BYTE          = 8'h01;
	localparam logic [7:0] DUMP_BYTE         = 8'hFE;
	localparam logic [7:0] SUM_OK            = 8'hFF;
	localparam logic [7:0] SAMPLE_TYPE_RESET = 8'h92;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_DUMP   = 1'b1;

	// one result from the parser, qualified by valid
	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] first;
		logic [7:0] second;
	} afr_result_t;

endpackage

// File: rtl/afr_parser.sv
module afr_parser import afr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [7:0]  cfg_write_data,
	input  logic        step,
	input  logic [7:0]  byte_in,
	output afr_result_t result
);

	typedef enum logic [4:0] {
		PH_HUNT   = 5'b00001,
		PH_LEN_HI = 5'b00010,
		PH_LEN_LO = 5'b00100,
		PH_BODY   = 5'b01000,
		PH_CMD    = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  sample_type_q;
	logic [7:0]  length_low_q, length_low_d;
	logic [8:0]  position_q, position_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  older_q, older_d;
	logic [7:0]  newer_q, newer_d;
	logic [7:0]  sum_next;
	logic [7:0]  first_eff;
	logic        at_end;

	assign sum_next  = sum_q + byte_in;
	assign first_eff = (position_q == 9'd0) ? byte_in : first_q;
	assign at_end    = (position_q == {1'b0, length_low_q});

	always_comb begin
		phase_d      = phase_q;
		length_low_d = length_low_q;
		position_d   = position_q;
		sum_d        = sum_q;
		first_d      = first_q;
		older_d      = older_q;
		newer_d      = newer_q;
		result       = '0;
		unique case (phase_q)
			PH_LEN_HI: begin
				older_d = byte_in;
				sum_d   = 8'd0;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_low_d = byte_in;
				newer_d      = byte_in;
				position_d   = 9'd0;
				phase_d      = PH_BODY;
			end
			PH_BODY: begin
				sum_d      = sum_next;
				first_d    = first_eff;
				position_d = position_q + 9'd1;
				if (at_end) begin
					if (sum_next == SUM_OK && first_eff == sample_type_q) begin
						result.valid  = 1'b1;
						result.kind   = KIND_SAMPLE;
						result.first  = older_q;
						result.second = newer_q;
					end
					phase_d = PH_HUNT;
				end else begin
					// shift the two-byte window
					older_d = newer_q;
					newer_d = byte_in;
				end
			end
			PH_CMD: begin
				if (byte_in == DUMP_BYTE) begin
					result.valid = 1'b1;
					result.kind  = KIND_DUMP;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				if (byte_in == DELIM_BYTE)
					phase_d = PH_LEN_HI;
				else if (byte_in == CMD_BYTE)
					phase_d = PH_CMD;
				else
					phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			sample_type_q <= SAMPLE_TYPE_RESET;
			length_low_q  <= 8'd0;
			position_q    <= 9'd0;
			sum_q         <= 8'd0;
			first_q       <= 8'd0;
			older_q       <= 8'd0;
			newer_q       <= 8'd0;
		end else begin
			if (cfg_write_en)
				sample_type_q <= cfg_write_data;
			if (step) begin
				phase_q      <= phase_d;
				length_low_q <= length_low_d;
				position_q   <= position_d;
				sum_q        <= sum_d;
				first_q      <= first_d;
				older_q      <= older_d;
				newer_q      <= newer_d;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_result_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (phase_q == PH_BODY || phase_q == PH_CMD))
		else $error("result outside body or command phase");

	a_body_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (position_q <= {1'b0, length_low_q}))
		else $error("body position ran past frame length");
`endif

endmodule

// File: rtl/api_frame_receiver.sv
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall  | rx_byte
// output  | out       | out_valid / out_stall| event_kind, sample_first, sample_second
// config  | in        | cfg_write_en         | cfg_write_data
//
// One byte per cycle sustained unless out_stall holds a pending result.
// The input register feeds the parser; the parser writes the result register.
// Reset returns the parser to hunting and sets the sample type to 0x92.
// A stalled result holds the result register; the input register then holds too.
module api_frame_receiver import afr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       event_kind,
	output logic [7:0] sample_first,
	output logic [7:0] sample_second
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        advance;
	afr_result_t result;
	logic        out_valid_s2;
	logic        kind_s2;
	logic [7:0]  first_s2;
	logic [7:0]  second_s2;

	assign out_free = !out_valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	afr_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.step           (advance),
		.byte_in        (byte_s1),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (out_free)
				out_valid_s2 <= advance && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
		if (advance && result.valid) begin
			kind_s2   <= result.kind;
			first_s2  <= result.first;
			second_s2 <= result.second;
		end
	end

	assign out_valid     = out_valid_s2;
	assign event_kind    = kind_s2;
	assign sample_first  = first_s2;
	assign sample_second = second_s2;

`ifndef NO_ASSERTIONS
	a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && out_stall) |-> !advance)
		else $error("parser advanced into a blocked result register");

	a_dump_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && kind_s2 == KIND_DUMP) |-> (first_s2 == 8'd0 && second_s2 == 8'd0))
		else $error("dump request carries nonzero sample bytes");
`endif

endmodule
